[rtl/scpa_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the size class pool allocator.
// Depends on nothing; every allocator file imports it.
package scpa_pkg;

  // Pool geometry. The smallest block size must be a power of two.
  localparam int NUM_CLASSES          = 5;
  localparam int BLOCKS_PER_CLASS     = 128;
  localparam int SMALLEST_BLOCK_BYTES = 4;

  localparam int SMALL_SHIFT = $clog2(SMALLEST_BLOCK_BYTES);
  localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SLOT_W      = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1;
  localparam int CNT_W       = $clog2(BLOCKS_PER_CLASS + 1);
  localparam int MEM_DEPTH   = NUM_CLASSES * BLOCKS_PER_CLASS;
  localparam int ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(BLOCKS_PER_CLASS);

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_OUTSIDE   = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // Decision made at request acceptance, carried to the result stage.
  typedef struct packed {
    op_e               op;
    logic [CLS_W-1:0]  cls;
    status_e           status;
    logic              use_orig;
    logic [SLOT_W-1:0] orig_slot;
  } scpa_dec_t;

  // Bytes in one block of class c.
  function automatic logic [31:0] block_bytes(input int unsigned c);
    return 32'(SMALLEST_BLOCK_BYTES) << c;
  endfunction

  // Bytes covered by the whole region of class c.
  function automatic logic [31:0] region_bytes(input int unsigned c);
    return 32'(block_bytes(c) * 32'(BLOCKS_PER_CLASS));
  endfunction

  // Offset of the region of class c from the arena base, modulo 2^32.
  function automatic logic [31:0] region_off(input int unsigned c);
    logic [31:0] off;
    off = 32'd0;
    for (int unsigned k = 0; k < c; k++) begin
      off = off + region_bytes(k);
    end
    return off;
  endfunction

endpackage

[rtl/size_class_pool_allocator_top.sv]
`timescale 1ns / 1ps
// Size class pool allocator: class select, per-class LIFO free stacks and result stage.
// Depends on scpa_pkg.
//
// A request's decision is registered in the decision stage, then its result in the result stage.
// Throughput: one request per cycle while in_stall_o is low; the stack pop or push of each request is
// one access to the slot memory, and each pop's read data is registered.
// Reset: free counts and low-water marks go to the full class depth at once. The slot
// memory is not cleared; an entry below its class low-water mark reads as its own index.
module size_class_pool_allocator_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [31:0]           cfg_data_i,
  // Request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic [15:0]           request_bytes_i,
  input  logic [31:0]           block_address_i,
  // Result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [31:0]           granted_address_o,
  output logic [2:0]            size_class_o,
  output logic [2:0]            status_o
);
  import scpa_pkg::*;

  logic [31:0]       arena_base_q;
  logic [CNT_W-1:0]  cnt_q [NUM_CLASSES];
  logic [CNT_W-1:0]  lwm_q [NUM_CLASSES];
  logic [SLOT_W-1:0] slot_mem [MEM_DEPTH];
  logic [SLOT_W-1:0] rdata_q;

  logic              s1_valid_q;
  scpa_dec_t         s1_q, s1_d;
  logic              out_valid_q;
  logic [31:0]       granted_q, granted_d;
  logic [2:0]        class_q;
  status_e           status_q;

  logic              in_acc, s1_adv, out_free;

  // Configuration register is always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_base_q <= 32'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      arena_base_q <= cfg_data_i;
    end
  end

  // Pipeline flow control.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Allocate: the first class whose block holds the requested bytes.
  logic             alloc_found;
  logic [CLS_W-1:0] alloc_cls;

  always_comb begin
    alloc_found = 1'b0;
    alloc_cls   = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if ({16'd0, request_bytes_i} <= block_bytes(c)) begin
        alloc_found = 1'b1;
        alloc_cls   = CLS_W'(c);
      end
    end
  end

  // Release: the first region that holds the address, and the slot within it.
  logic              rel_found;
  logic [CLS_W-1:0]  rel_cls;
  logic [SLOT_W-1:0] rel_slot;

  always_comb begin
    logic [31:0] off;
    rel_found = 1'b0;
    rel_cls   = '0;
    rel_slot  = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      off = block_address_i - arena_base_q - region_off(c);
      if (off < region_bytes(c)) begin
        rel_found = 1'b1;
        rel_cls   = CLS_W'(c);
        rel_slot  = SLOT_W'(off >> (SMALL_SHIFT + c));
      end
    end
  end

  // Decision, stack pointer update and memory access for the accepted request.
  logic [CLS_W-1:0]  sel_cls;
  logic [CNT_W-1:0]  sel_cnt, sel_lwm, pop_cnt, push_cnt;
  logic              do_pop, do_push;
  logic [ADDR_W-1:0] class_base;

  assign sel_cls    = (operation_i == OP_RELEASE) ? rel_cls : alloc_cls;
  assign sel_cnt    = cnt_q[sel_cls];
  assign sel_lwm    = lwm_q[sel_cls];
  assign pop_cnt    = sel_cnt - CNT_W'(1);
  assign push_cnt   = sel_cnt + CNT_W'(1);
  assign class_base = ADDR_W'(ADDR_W'(sel_cls) * ADDR_W'(BLOCKS_PER_CLASS));

  always_comb begin
    do_pop         = 1'b0;
    do_push        = 1'b0;
    s1_d.op        = op_e'(operation_i);
    s1_d.cls       = sel_cls;
    s1_d.status    = ST_OK;
    s1_d.use_orig  = pop_cnt < sel_lwm;
    s1_d.orig_slot = SLOT_W'(pop_cnt);
    if (operation_i == OP_ALLOC) begin
      if (!alloc_found) begin
        s1_d.status = ST_TOO_LARGE;
        s1_d.cls    = '0;
      end else if (sel_cnt == '0) begin
        s1_d.status = ST_EMPTY;
      end else begin
        do_pop = in_acc;
      end
    end else begin
      if (!rel_found) begin
        s1_d.status = ST_OUTSIDE;
        s1_d.cls    = '0;
      end else if (sel_cnt >= FULL_COUNT) begin
        s1_d.status = ST_FULL;
      end else begin
        do_push = in_acc;
      end
    end
  end

  // Free counts and low-water marks per class.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cnt_q[c] <= FULL_COUNT;
        lwm_q[c] <= FULL_COUNT;
      end
    end else if (do_pop) begin
      cnt_q[sel_cls] <= pop_cnt;
      if (pop_cnt < sel_lwm) begin
        lwm_q[sel_cls] <= pop_cnt;
      end
    end else if (do_push) begin
      cnt_q[sel_cls] <= push_cnt;
    end
  end

  // Slot memory: a push writes at the stack top, a pop reads below it.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_mem[class_base + ADDR_W'(sel_cnt[SLOT_W-1:0])] <= rel_slot;
    end
    if (do_pop) begin
      rdata_q <= slot_mem[class_base + ADDR_W'(s1_d.orig_slot)];
    end
  end

  // Decision register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // Result stage: build the granted address from the popped slot.
  logic [31:0]       region_off_tab [NUM_CLASSES];
  logic [SLOT_W-1:0] pop_slot;

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      region_off_tab[c] = region_off(c);
    end
  end

  assign pop_slot = s1_q.use_orig ? s1_q.orig_slot : rdata_q;

  always_comb begin
    granted_d = 32'd0;
    if (s1_q.op == OP_ALLOC && s1_q.status == ST_OK) begin
      granted_d = arena_base_q + region_off_tab[s1_q.cls] +
                  (32'(pop_slot) << (SMALL_SHIFT + int'(s1_q.cls)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      granted_q <= granted_d;
      class_q   <= 3'(s1_q.cls);
      status_q  <= s1_q.status;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = granted_q;
  assign size_class_o      = class_q;
  assign status_o          = status_q;

  // Checks on the allocator's own bookkeeping.
  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cnt_chk
    a_lwm_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
      lwm_q[g] <= cnt_q[g] && cnt_q[g] <= FULL_COUNT)
      else $error("class count or low-water mark out of order");
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && s1_valid_q && !s1_adv))
    else $error("request accepted while the decision stage is blocked");

  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> granted_address_o == 32'd0)
    else $error("failed request carries an address");

  a_pop_push_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(do_pop && do_push))
    else $error("pop and push in the same cycle");

  a_pop_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |=> cnt_q[$past(sel_cls)] == $past(pop_cnt))
    else $error("pop did not lower the class count");

endmodule
